[sv/lcr_pkg.sv]
`timescale 1ns / 1ps

package lcr_pkg;

  localparam int CoordBits = 16;
  // Magnitudes of edge distances and deltas fit one bit above the coordinate width.
  localparam int MagBits   = CoordBits + 1;
  localparam int ProdBits  = 2 * MagBits;
  localparam int ExtBits   = CoordBits + 2;
  localparam int NumSteps  = 4;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegClipWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegClipHeight = 1'd1;

  localparam int OcTop    = 0;
  localparam int OcBottom = 1;
  localparam int OcLeft   = 2;
  localparam int OcRight  = 3;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic                        visible;
    logic signed [CoordBits-1:0] clipped_start_x;
    logic signed [CoordBits-1:0] clipped_start_y;
    logic signed [CoordBits-1:0] clipped_end_x;
    logic signed [CoordBits-1:0] clipped_end_y;
  } out_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic [3:0]                  ca;
    logic [3:0]                  cb;
    logic                        done;
    logic                        vis;
    logic                        active;
    logic                        sel_b;
    logic [3:0]                  edge_sel;
    logic                        neg;
    logic                        dz;
    logic [MagBits-1:0]          ma;
    logic [MagBits-1:0]          mb;
    logic [MagBits-1:0]          den;
    logic [ProdBits-1:0]         z;
  } work_t;

  function automatic logic [3:0] outcode(input logic signed [CoordBits-1:0] x,
                                         input logic signed [CoordBits-1:0] y,
                                         input logic signed [CoordBits:0]   cx,
                                         input logic signed [CoordBits:0]   cy);
    logic [3:0]                c;
    logic signed [CoordBits:0] xe;
    logic signed [CoordBits:0] ye;
    c  = '0;
    xe = {x[CoordBits-1], x};
    ye = {y[CoordBits-1], y};
    if (ye < 0) begin
      c[OcTop] = 1'b1;
    end else if (ye > cy) begin
      c[OcBottom] = 1'b1;
    end
    if (xe < 0) begin
      c[OcLeft] = 1'b1;
    end else if (xe > cx) begin
      c[OcRight] = 1'b1;
    end
    return c;
  endfunction

endpackage

[sv/line_clip_to_rectangle.sv]
`timescale 1ns / 1ps

// Cohen-Sutherland clipper of one segment against (0,0)..(width-1,height-1).
// Input channel: in_valid_i / in_stall_o with in_data_i; a transaction moves
// when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i with out_data_o, same rule. Configuration: cfg_valid_i with
// cfg_index_i (0 = width, 1 = height) and cfg_data_i, always ready; write only
// while no segment is in flight.
// The pipeline has one input stage, four clip steps of 20 stages each
// (select edge, 17x17 multiply, 17 stages of one quotient bit each, move the
// endpoint) and one output register. A new segment enters every cycle unless
// the output stalls; the restoring divider stages set the depth.
// Reset clears every valid bit and loads width 1920 and height 1080.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Endpoints are reported as the clip steps left them, also when rejected.
module line_clip_to_rectangle
  import lcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int QBits = MagBits;

  logic [15:0] width_q, height_q;
  logic signed [CoordBits:0] cx, cy;
  logic en;

  work_t st_q [NumSteps+1];
  logic  st_v_q [NumSteps+1];
  work_t st0_d;
  out_t  out_q, out_d;
  logic  out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1920;
      height_q <= 16'd1080;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegClipWidth:  width_q  <= cfg_data_i;
        RegClipHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero size gives a corner of -1, so nothing lies inside.
  assign cx = $signed({1'b0, width_q}) - 17'sd1;
  assign cy = $signed({1'b0, height_q}) - 17'sd1;

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    st0_d    = '0;
    st0_d.ax = in_data_i.start_x;
    st0_d.ay = in_data_i.start_y;
    st0_d.bx = in_data_i.end_x;
    st0_d.by = in_data_i.end_y;
    st0_d.ca = outcode(in_data_i.start_x, in_data_i.start_y, cx, cy);
    st0_d.cb = outcode(in_data_i.end_x, in_data_i.end_y, cx, cy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else if (en) begin
      st_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    work_t dv_q [QBits+1];
    logic  dv_v_q [QBits+1];
    work_t dec_d, dec_q, mul_d, upd_d;
    logic  dec_v_q;

    // Pick the endpoint and edge, form the three signed differences.
    always_comb begin
      logic [3:0]               pc;
      logic signed [ExtBits-1:0] px, py, ox, oy, num, span, den, cxe, cye;
      dec_d = st_q[k];
      dec_d.active = 1'b0;
      dec_d.sel_b  = 1'b0;
      dec_d.edge_sel = '0;
      dec_d.neg = 1'b0;
      dec_d.dz  = 1'b0;
      dec_d.ma  = '0;
      dec_d.mb  = '0;
      dec_d.den = '0;
      pc  = '0;
      cxe = {cx[CoordBits], cx};
      cye = {cy[CoordBits], cy};
      px  = '0;
      py  = '0;
      ox  = '0;
      oy  = '0;
      num = '0;
      span = '0;
      den = '0;
      if (!st_q[k].done) begin
        if ((st_q[k].ca | st_q[k].cb) == 4'd0) begin
          dec_d.done = 1'b1;
          dec_d.vis  = 1'b1;
        end else if ((st_q[k].ca & st_q[k].cb) != 4'd0) begin
          dec_d.done = 1'b1;
        end else begin
          dec_d.active = 1'b1;
          dec_d.sel_b  = (st_q[k].ca == 4'd0);
          if (dec_d.sel_b) begin
            pc = st_q[k].cb;
            px = ExtBits'(st_q[k].bx);
            py = ExtBits'(st_q[k].by);
            ox = ExtBits'(st_q[k].ax);
            oy = ExtBits'(st_q[k].ay);
          end else begin
            pc = st_q[k].ca;
            px = ExtBits'(st_q[k].ax);
            py = ExtBits'(st_q[k].ay);
            ox = ExtBits'(st_q[k].bx);
            oy = ExtBits'(st_q[k].by);
          end
          // lowest set bit wins: top, bottom, left, right
          dec_d.edge_sel = pc & (~pc + 4'd1);
          if (dec_d.edge_sel[OcTop] || dec_d.edge_sel[OcBottom]) begin
            num  = ox - px;
            span = dec_d.edge_sel[OcTop] ? -py : cye - py;
            den  = oy - py;
          end else begin
            num  = oy - py;
            span = dec_d.edge_sel[OcLeft] ? -px : cxe - px;
            den  = ox - px;
          end
          dec_d.ma  = MagBits'(num[ExtBits-1] ? -num : num);
          dec_d.mb  = MagBits'(span[ExtBits-1] ? -span : span);
          dec_d.den = MagBits'(den[ExtBits-1] ? -den : den);
          dec_d.neg = num[ExtBits-1] ^ span[ExtBits-1] ^ den[ExtBits-1];
          dec_d.dz  = (den == '0);
        end
      end
    end

    always_comb begin
      mul_d   = dec_q;
      mul_d.z = dec_q.ma * dec_q.mb;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dec_v_q   <= 1'b0;
        dv_v_q[0] <= 1'b0;
      end else if (en) begin
        dec_v_q   <= st_v_q[k];
        dv_v_q[0] <= dec_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dec_q    <= dec_d;
        dv_q[0]  <= mul_d;
      end
    end

    // Restoring division, one quotient bit per stage; quotient stays below 2^QBits.
    for (genvar i = 0; i < QBits; i++) begin : g_div
      work_t div_d;
      always_comb begin
        logic [MagBits:0] t;
        logic             ge;
        div_d = dv_q[i];
        t  = dv_q[i].z[ProdBits-1:MagBits-1];
        ge = (t >= {1'b0, dv_q[i].den});
        if (ge) begin
          t = t - {1'b0, dv_q[i].den};
        end
        div_d.z = {t[MagBits-1:0], dv_q[i].z[MagBits-2:0], ge};
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_v_q[i+1] <= 1'b0;
        end else if (en) begin
          dv_v_q[i+1] <= dv_v_q[i];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[i+1] <= div_d;
        end
      end
    end

    // Move the endpoint onto the edge and recompute its code.
    always_comb begin
      logic [MagBits-1:0]        q;
      logic signed [ExtBits-1:0] qs, delta, px, py, sum;
      logic signed [CoordBits-1:0] nx, ny;
      upd_d = dv_q[QBits];
      q     = dv_q[QBits].dz ? '0 : dv_q[QBits].z[MagBits-1:0];
      qs    = {1'b0, q};
      delta = dv_q[QBits].neg ? -qs : qs;
      px = dv_q[QBits].sel_b ? ExtBits'(dv_q[QBits].bx) : ExtBits'(dv_q[QBits].ax);
      py = dv_q[QBits].sel_b ? ExtBits'(dv_q[QBits].by) : ExtBits'(dv_q[QBits].ay);
      sum = '0;
      if (dv_q[QBits].edge_sel[OcTop] || dv_q[QBits].edge_sel[OcBottom]) begin
        sum = px + delta;
        nx  = sum[CoordBits-1:0];
        ny  = dv_q[QBits].edge_sel[OcTop] ? '0 : cy[CoordBits-1:0];
      end else begin
        sum = py + delta;
        ny  = sum[CoordBits-1:0];
        nx  = dv_q[QBits].edge_sel[OcLeft] ? '0 : cx[CoordBits-1:0];
      end
      if (dv_q[QBits].active) begin
        if (dv_q[QBits].sel_b) begin
          upd_d.bx = nx;
          upd_d.by = ny;
          upd_d.cb = outcode(nx, ny, cx, cy);
        end else begin
          upd_d.ax = nx;
          upd_d.ay = ny;
          upd_d.ca = outcode(nx, ny, cx, cy);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[k+1] <= 1'b0;
      end else if (en) begin
        st_v_q[k+1] <= dv_v_q[QBits];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= upd_d;
      end
    end
  end

  always_comb begin
    out_d.visible = st_q[NumSteps].done ? st_q[NumSteps].vis
                                        : ((st_q[NumSteps].ca | st_q[NumSteps].cb) == 4'd0);
    out_d.clipped_start_x = st_q[NumSteps].ax;
    out_d.clipped_start_y = st_q[NumSteps].ay;
    out_d.clipped_end_x   = st_q[NumSteps].bx;
    out_d.clipped_end_y   = st_q[NumSteps].by;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= st_v_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  a_visible_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.visible |->
      (outcode(out_data_o.clipped_start_x, out_data_o.clipped_start_y, cx, cy) == 4'd0) &&
      (outcode(out_data_o.clipped_end_x, out_data_o.clipped_end_y, cx, cy) == 4'd0))
    else $error("visible segment has an endpoint outside");

  a_reject_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |->
      ((outcode(out_data_o.clipped_start_x, out_data_o.clipped_start_y, cx, cy) &
        outcode(out_data_o.clipped_end_x, out_data_o.clipped_end_y, cx, cy)) != 4'd0))
    else $error("rejected segment without a shared outcode bit");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule
